/* rtl/assert_macros.svh */
// Assertion macros used by the checker file of this project.
// No dependencies; include once per file that asserts.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// antecedent implies consequent in the same cycle
`define ASSERT_IMPL(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("%m: same-cycle implication failed");

// antecedent implies consequent in the next cycle
`define ASSERT_NEXT(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("%m: next-cycle implication failed");

`endif

/* rtl/sha_pkg.sv */
// Shared types, constants and functions for the SHA-256 stream hash block.
// No dependencies.
`default_nettype none

package sha_pkg;

  localparam int unsigned BLOCK_BYTES = 64;
  localparam int unsigned LEN_POS     = 56;
  localparam logic [7:0]  PAD_BYTE    = 8'h80;
  localparam int unsigned ROUNDS      = 64;
  localparam int unsigned HASH_WORDS  = 8;
  localparam int unsigned SCHED_WORDS = 16;

  localparam logic [31:0] IV_TAB [HASH_WORDS] = '{
    32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
    32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
  };

  localparam logic [31:0] K_TAB [ROUNDS] = '{
    32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
    32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
    32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
    32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
    32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
    32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
    32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
    32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
    32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
    32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
    32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
    32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
    32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
    32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
    32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
    32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
  };

  // schedule window controls
  typedef struct packed {
    logic       push;       // shift one byte into the block
    logic [7:0] push_byte;
    logic       roll;       // advance the message schedule by one word
  } sched_ctl_t;

  // round datapath controls
  typedef struct packed {
    logic       load;       // working vars <= hash
    logic       step;       // one compression round
    logic       fold;       // hash += working vars
    logic       shift_out;  // move next digest word up, refill with IV
    logic [5:0] rnd;
    logic [2:0] out_idx;
  } round_ctl_t;

  function automatic logic [31:0] rotr(input logic [31:0] x, input int unsigned n);
    rotr = (x >> n) | (x << (32 - n));
  endfunction

  function automatic logic [31:0] big_s0(input logic [31:0] x);
    big_s0 = rotr(x, 2) ^ rotr(x, 13) ^ rotr(x, 22);
  endfunction

  function automatic logic [31:0] big_s1(input logic [31:0] x);
    big_s1 = rotr(x, 6) ^ rotr(x, 11) ^ rotr(x, 25);
  endfunction

  function automatic logic [31:0] small_s0(input logic [31:0] x);
    small_s0 = rotr(x, 7) ^ rotr(x, 18) ^ (x >> 3);
  endfunction

  function automatic logic [31:0] small_s1(input logic [31:0] x);
    small_s1 = rotr(x, 17) ^ rotr(x, 19) ^ (x >> 10);
  endfunction

endpackage

`default_nettype wire

/* rtl/sha256_stream_hash_unit.sv */
// SHA-256 stream hash top level: sequencer, byte count and padding control.
// Depends on sha_pkg, sha_sched and sha_round.
//
// Input channel (in_valid/in_stall, op, data_byte): op 0 absorbs one message
// byte, op 1 closes the message. in_stall is high whenever the sequencer is
// busy; an absorb that does not fill a block leaves the sequencer idle.
// Every 64th byte starts a compression: 64 rounds on the single round unit,
// one round per cycle, followed by a fold into the hash words.
// A finish pushes 0x80, zero padding and the 8-byte bit length through the
// same byte path at one byte per cycle, with one or two compressions, and
// then presents the digest: 8 transfers on the output channel
// (out_valid/out_stall, digest_word, word_index, last_word), word 0 first,
// last_word set on word 7.
// A stalled output word holds steady; input stays stalled until word 7 has
// been taken, after which the hash is back at its initial values.
// Synchronous reset returns to idle with an empty block, zero byte count
// and the initial hash values.
`default_nettype none

module sha256_stream_hash_unit import sha_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic        op,
  input  logic [7:0]  data_byte,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [31:0] digest_word,
  output logic [2:0]  word_index,
  output logic        last_word
);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_PAD1 = 3'd1;
  localparam logic [2:0] S_PADZ = 3'd2;
  localparam logic [2:0] S_PADL = 3'd3;
  localparam logic [2:0] S_RND  = 3'd4;
  localparam logic [2:0] S_FOLD = 3'd5;
  localparam logic [2:0] S_OUT  = 3'd6;

  localparam logic [5:0] FILL_LAST = 6'(BLOCK_BYTES - 1);
  localparam logic [5:0] FILL_LEN  = 6'(LEN_POS);
  localparam logic [5:0] RND_LAST  = 6'(ROUNDS - 1);
  localparam logic [2:0] IDX_LAST  = 3'(HASH_WORDS - 1);

  logic [2:0]  state, state_next;
  logic [2:0]  resume, resume_next;
  logic [5:0]  fill, fill_next;
  logic [5:0]  rnd, rnd_next;
  logic [2:0]  idx, idx_next;
  logic [60:0] msg_bytes, msg_bytes_next;
  logic [63:0] len_bits, len_bits_next;

  sched_ctl_t  sctl;
  round_ctl_t  rctl;
  logic [31:0] w_cur;

  assign in_stall   = (state != S_IDLE);
  assign out_valid  = (state == S_OUT);
  assign word_index = idx;
  assign last_word  = (idx == IDX_LAST);

  always_comb begin
    state_next     = state;
    resume_next    = resume;
    fill_next      = fill;
    rnd_next       = rnd;
    idx_next       = idx;
    msg_bytes_next = msg_bytes;
    len_bits_next  = len_bits;
    sctl           = '0;
    rctl           = '0;
    rctl.rnd       = rnd;
    rctl.out_idx   = idx;

    unique case (state)
      S_IDLE: begin
        if (in_valid) begin
          if (!op) begin
            sctl.push      = 1'b1;
            sctl.push_byte = data_byte;
            fill_next      = fill + 6'd1;
            msg_bytes_next = msg_bytes + 61'd1;
            if (fill == FILL_LAST) begin
              rctl.load   = 1'b1;
              rnd_next    = '0;
              resume_next = S_IDLE;
              state_next  = S_RND;
            end
          end else begin
            len_bits_next  = {msg_bytes, 3'b000};
            msg_bytes_next = '0;
            state_next     = S_PAD1;
          end
        end
      end
      S_PAD1: begin
        sctl.push      = 1'b1;
        sctl.push_byte = PAD_BYTE;
        fill_next      = fill + 6'd1;
        state_next     = S_PADZ;
        if (fill == FILL_LAST) begin
          rctl.load   = 1'b1;
          rnd_next    = '0;
          resume_next = S_PADZ;
          state_next  = S_RND;
        end
      end
      S_PADZ: begin
        if (fill == FILL_LEN) begin
          state_next = S_PADL;
        end else begin
          sctl.push      = 1'b1;
          sctl.push_byte = 8'h00;
          fill_next      = fill + 6'd1;
          if (fill == FILL_LAST) begin
            rctl.load   = 1'b1;
            rnd_next    = '0;
            resume_next = S_PADZ;
            state_next  = S_RND;
          end
        end
      end
      S_PADL: begin
        // length bytes go out most significant first; the eighth fills the block
        sctl.push      = 1'b1;
        sctl.push_byte = len_bits[63:56];
        len_bits_next  = {len_bits[55:0], 8'h00};
        fill_next      = fill + 6'd1;
        if (fill == FILL_LAST) begin
          rctl.load   = 1'b1;
          rnd_next    = '0;
          idx_next    = '0;
          resume_next = S_OUT;
          state_next  = S_RND;
        end
      end
      S_RND: begin
        rctl.step = 1'b1;
        sctl.roll = 1'b1;
        rnd_next  = rnd + 6'd1;
        if (rnd == RND_LAST) begin
          state_next = S_FOLD;
        end
      end
      S_FOLD: begin
        rctl.fold  = 1'b1;
        state_next = resume;
      end
      S_OUT: begin
        if (!out_stall) begin
          rctl.shift_out = 1'b1;
          idx_next       = idx + 3'd1;
          if (idx == IDX_LAST) begin
            state_next = S_IDLE;
          end
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      resume    <= S_IDLE;
      fill      <= '0;
      rnd       <= '0;
      idx       <= '0;
      msg_bytes <= '0;
    end else begin
      state     <= state_next;
      resume    <= resume_next;
      fill      <= fill_next;
      rnd       <= rnd_next;
      idx       <= idx_next;
      msg_bytes <= msg_bytes_next;
    end
  end

  always_ff @(posedge clk) begin
    len_bits <= len_bits_next;
  end

  sha_sched u_sched (
    .clk   (clk),
    .ctl   (sctl),
    .w_cur (w_cur)
  );

  sha_round u_round (
    .clk         (clk),
    .rst         (rst),
    .ctl         (rctl),
    .w           (w_cur),
    .digest_word (digest_word)
  );

endmodule

`default_nettype wire

/* rtl/sha_sched.sv */
// Block buffer and rolling message schedule: a 16-word window that takes
// bytes in during absorb and rolls one word per round. Depends on sha_pkg.
`default_nettype none

module sha_sched import sha_pkg::*; (
  input  logic       clk,
  input  sched_ctl_t ctl,
  output logic [31:0] w_cur
);

  logic [31:0] win [SCHED_WORDS];
  logic [31:0] w_new;

  assign w_cur = win[0];
  assign w_new = small_s1(win[14]) + win[9] + small_s0(win[1]) + win[0];

  always_ff @(posedge clk) begin
    if (ctl.push) begin
      // whole window acts as one 512-bit byte shifter, first byte ends up on top
      for (int i = 0; i < SCHED_WORDS - 1; i++) begin
        win[i] <= {win[i][23:0], win[i+1][31:24]};
      end
      win[SCHED_WORDS-1] <= {win[SCHED_WORDS-1][23:0], ctl.push_byte};
    end else if (ctl.roll) begin
      for (int i = 0; i < SCHED_WORDS - 1; i++) begin
        win[i] <= win[i+1];
      end
      win[SCHED_WORDS-1] <= w_new;
    end
  end

endmodule

`default_nettype wire

/* rtl/sha_round.sv */
// Shared compression round unit with the working variables and hash words.
// Depends on sha_pkg.
`default_nettype none

module sha_round import sha_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  round_ctl_t  ctl,
  input  logic [31:0] w,
  output logic [31:0] digest_word
);

  logic [31:0] work [HASH_WORDS];
  logic [31:0] hash [HASH_WORDS];
  logic [31:0] t1;
  logic [31:0] t2;

  always_comb begin
    t1 = work[7] + big_s1(work[4]) + ((work[4] & work[5]) ^ (~work[4] & work[6]))
       + K_TAB[ctl.rnd] + w;
    t2 = big_s0(work[0]) + ((work[0] & work[1]) ^ (work[0] & work[2]) ^ (work[1] & work[2]));
  end

  assign digest_word = hash[0];

  always_ff @(posedge clk) begin
    if (ctl.load) begin
      for (int i = 0; i < HASH_WORDS; i++) begin
        work[i] <= hash[i];
      end
    end else if (ctl.step) begin
      work[7] <= work[6];
      work[6] <= work[5];
      work[5] <= work[4];
      work[4] <= work[3] + t1;
      work[3] <= work[2];
      work[2] <= work[1];
      work[1] <= work[0];
      work[0] <= t1 + t2;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < HASH_WORDS; i++) begin
        hash[i] <= IV_TAB[i];
      end
    end else if (ctl.fold) begin
      for (int i = 0; i < HASH_WORDS; i++) begin
        hash[i] <= hash[i] + work[i];
      end
    end else if (ctl.shift_out) begin
      // after eight shifts the hash holds the initial values again
      for (int i = 0; i < HASH_WORDS - 1; i++) begin
        hash[i] <= hash[i+1];
      end
      hash[HASH_WORDS-1] <= IV_TAB[ctl.out_idx];
    end
  end

endmodule

`default_nettype wire

/* rtl/sha_checker.sv */
// Port-level checker for the SHA-256 stream hash unit, bound to the top level.
// Depends on assert_macros.svh.
`default_nettype none
`include "assert_macros.svh"

module sha_checker (
  input wire logic        clk,
  input wire logic        rst,
  input wire logic        in_stall,
  input wire logic        out_valid,
  input wire logic        out_stall,
  input wire logic [31:0] digest_word,
  input wire logic [2:0]  word_index,
  input wire logic        last_word
);

  logic out_go;

  assign out_go = out_valid && !out_stall;

  // no input transfer while a digest is being delivered
  `ASSERT_IMPL(a_busy_during_out, clk, rst, out_valid, in_stall)
  // digest words come as one unbroken burst
  `ASSERT_NEXT(a_burst_cont, clk, rst, out_go && !last_word, out_valid)
  `ASSERT_NEXT(a_idx_step, clk, rst, out_go && !last_word, word_index == $past(word_index) + 3'd1)
  // burst ends after the last word
  `ASSERT_NEXT(a_burst_end, clk, rst, out_go && last_word, !out_valid)
  // stalled word holds
  `ASSERT_NEXT(a_out_hold, clk, rst, out_valid && out_stall, out_valid && $stable(digest_word))

endmodule

bind sha256_stream_hash_unit sha_checker u_sha_checker (.*);

`default_nettype wire
